// ===== hw/rtl/floppy_track_format_stream_defines.svh =====
// Assertion macros for the floppy track format stream RTL.
`ifndef FLOPPY_TRACK_FORMAT_STREAM_DEFINES_SVH
`define FLOPPY_TRACK_FORMAT_STREAM_DEFINES_SVH

// clocked check, off during reset
`define FTF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on the following cycle
`define FTF_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== hw/rtl/ftf_pkg.sv =====
// Types, constants and segment functions for the floppy track format stream.
package ftf_pkg;

	localparam logic [9:0] SECTOR_BYTES    = 10'd512;
	localparam logic [9:0] FINAL_GAP_BYTES = 10'd598;

	localparam logic [7:0] FILL_SD   = 8'hFF;
	localparam logic [7:0] FILL_DD   = 8'h4E;
	localparam logic [7:0] PRE_INDEX = 8'hF6;
	localparam logic [7:0] PRE_ADDR  = 8'hF5;
	localparam logic [7:0] MARK_IDX  = 8'hFC;
	localparam logic [7:0] MARK_ID   = 8'hFE;
	localparam logic [7:0] MARK_DATA = 8'hFB;
	localparam logic [7:0] CRC_TOKEN = 8'hF7;
	localparam logic [7:0] DATA_FILL = 8'h69;
	localparam logic [7:0] SIZE_CODE = 8'h02;
	localparam logic [7:0] SIDE_ZERO = 8'h00;

	localparam logic [1:0] REG_TRACK  = 2'd0;
	localparam logic [1:0] REG_COUNT  = 2'd1;
	localparam logic [1:0] REG_DOUBLE = 2'd2;

	typedef enum logic [4:0] {
		SEG_IDX_GAP  = 5'd0,
		SEG_IDX_SYNC = 5'd1,
		SEG_IDX_PRE  = 5'd2,
		SEG_IDX_MARK = 5'd3,
		SEG_POST_GAP = 5'd4,
		SEG_SYNC1    = 5'd5,
		SEG_PRE1     = 5'd6,
		SEG_IDAM     = 5'd7,
		SEG_TRACK    = 5'd8,
		SEG_SIDE     = 5'd9,
		SEG_SECNUM   = 5'd10,
		SEG_SIZE     = 5'd11,
		SEG_CRC1     = 5'd12,
		SEG_GAP2     = 5'd13,
		SEG_SYNC2    = 5'd14,
		SEG_PRE2     = 5'd15,
		SEG_DAM      = 5'd16,
		SEG_DATA     = 5'd17,
		SEG_CRC2     = 5'd18,
		SEG_GAP3     = 5'd19,
		SEG_FINAL    = 5'd20
	} seg_t;

	typedef struct packed {
		logic [7:0] track_number;
		logic [4:0] sector_count;
		logic       dd_mode;
	} cfg_t;

	typedef struct packed {
		seg_t       seg;
		logic [9:0] bis;
		logic [4:0] sec;
	} pos_t;

	function automatic logic [9:0] seg_len(seg_t seg, logic dd);
		logic [9:0] len;
		case (seg) inside
			SEG_IDX_GAP:                         len = 10'd40;
			SEG_IDX_SYNC, SEG_SYNC1, SEG_SYNC2:  len = dd ? 10'd12 : 10'd6;
			SEG_IDX_PRE, SEG_PRE1, SEG_PRE2:     len = dd ? 10'd3 : 10'd0;
			SEG_POST_GAP:                        len = dd ? 10'd50 : 10'd26;
			SEG_GAP2:                            len = dd ? 10'd22 : 10'd11;
			SEG_DATA:                            len = SECTOR_BYTES;
			SEG_GAP3:                            len = dd ? 10'd54 : 10'd27;
			SEG_FINAL:                           len = FINAL_GAP_BYTES;
			default:                             len = 10'd1;
		endcase
		return len;
	endfunction

	function automatic pos_t next_seg(pos_t p, cfg_t c);
		pos_t r;
		r = p;
		r.bis = '0;
		if (p.seg == SEG_POST_GAP) begin
			r.sec = '0;
			r.seg = (c.sector_count == 5'd0) ? SEG_FINAL : SEG_SYNC1;
		end else if (p.seg == SEG_GAP3) begin
			if (({1'b0, p.sec} + 6'd1) >= {1'b0, c.sector_count}) begin
				r.seg = SEG_FINAL;
			end else begin
				r.sec = p.sec + 5'd1;
				r.seg = SEG_SYNC1;
			end
		end else if (p.seg >= SEG_FINAL) begin
			r.seg = SEG_IDX_GAP;
			r.sec = '0;
		end else begin
			r.seg = seg_t'(p.seg + 5'd1);
		end
		return r;
	endfunction

	// one overflow step, then at most one empty preamble to skip
	function automatic pos_t normalize(pos_t p, cfg_t c);
		pos_t r;
		r = p;
		if (r.bis >= seg_len(r.seg, c.dd_mode)) r = next_seg(r, c);
		if (r.bis >= seg_len(r.seg, c.dd_mode)) r = next_seg(r, c);
		return r;
	endfunction

	function automatic logic [7:0] seg_byte(pos_t p, cfg_t c);
		logic [7:0] b;
		case (p.seg) inside
			SEG_IDX_GAP, SEG_POST_GAP, SEG_GAP2, SEG_GAP3, SEG_FINAL:
				b = c.dd_mode ? FILL_DD : FILL_SD;
			SEG_IDX_PRE:         b = PRE_INDEX;
			SEG_PRE1, SEG_PRE2:  b = PRE_ADDR;
			SEG_IDX_MARK:        b = MARK_IDX;
			SEG_IDAM:            b = MARK_ID;
			SEG_TRACK:           b = c.track_number;
			SEG_SIDE:            b = SIDE_ZERO;
			SEG_SECNUM:          b = {3'b000, p.sec} + 8'd1;
			SEG_SIZE:            b = SIZE_CODE;
			SEG_CRC1, SEG_CRC2:  b = CRC_TOKEN;
			SEG_DAM:             b = MARK_DATA;
			SEG_DATA:            b = DATA_FILL;
			default:             b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== hw/rtl/ftf_if.sv =====
// Handshake channel interfaces for request and track byte words.
interface ftf_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface ftf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] track_byte;
	logic       last_byte;

	modport source (output valid, output track_byte, output last_byte, input ready);
	modport sink (input valid, input track_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/ftf_apb_regs.sv =====
// APB configuration registers: track number, sector count, density.
module ftf_apb_regs
	import ftf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.track_number <= 8'd0;
			cfg_q.sector_count <= 5'd26;
			cfg_q.dd_mode      <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_TRACK:  cfg_q.track_number <= pwdata[7:0];
				REG_COUNT:  cfg_q.sector_count <= pwdata[4:0];
				REG_DOUBLE: cfg_q.dd_mode      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TRACK:  prdata = {24'd0, cfg_q.track_number};
			REG_COUNT:  prdata = {27'd0, cfg_q.sector_count};
			REG_DOUBLE: prdata = {31'd0, cfg_q.dd_mode};
			default:    prdata = 32'd0;
		endcase
	end

endmodule

// ===== hw/rtl/ftf_engine.sv =====
// Input register, track position state and track byte result register.
`include "floppy_track_format_stream_defines.svh"

module ftf_engine
	import ftf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	ftf_req_if.sink   req,
	ftf_rsp_if.source rsp
);

	logic       valid_s1;
	logic       restart_s1;
	logic       valid_s2;
	logic [7:0] track_byte_s2;
	logic       last_byte_s2;
	pos_t       pos_q;

	logic       adv;
	pos_t       pos_start;
	pos_t       pos_cur;
	pos_t       pos_step;
	pos_t       pos_next;
	logic [7:0] byte_cur;
	logic       last_cur;
	logic [7:0] fill;

	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	assign fill      = cfg.dd_mode ? FILL_DD : FILL_SD;
	assign pos_start = restart_s1 ? '0 : pos_q;
	assign pos_cur   = normalize(pos_start, cfg);
	assign byte_cur  = seg_byte(pos_cur, cfg);
	assign last_cur  = (pos_cur.seg == SEG_FINAL) && (pos_cur.bis == FINAL_GAP_BYTES - 10'd1);

	always_comb begin
		pos_step     = pos_cur;
		pos_step.bis = pos_cur.bis + 10'd1;
		pos_next     = normalize(pos_step, cfg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (req.ready) valid_s1 <= req.valid;
			if (adv) begin
				valid_s2 <= 1'b1;
				pos_q    <= pos_next;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) restart_s1 <= req.restart;
		if (adv) begin
			track_byte_s2 <= byte_cur;
			last_byte_s2  <= last_cur;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.track_byte = track_byte_s2;
	assign rsp.last_byte  = last_byte_s2;

	`FTF_ASSERT_NEXT(a_adv_fills_out, adv, valid_s2, "advanced word did not reach output")
	`FTF_ASSERT_NEXT(a_wrap_after_last, adv && last_cur,
		pos_q.seg == SEG_IDX_GAP && pos_q.bis == 10'd0 && pos_q.sec == 5'd0,
		"no wrap to index gap after last byte")
	`FTF_ASSERT_NEXT(a_restart_gap, adv && restart_s1, track_byte_s2 == fill,
		"restart did not emit index gap fill")
	`FTF_ASSERT(a_last_is_fill, !(valid_s2 && last_byte_s2) || track_byte_s2 == fill,
		"last byte is not gap fill")

endmodule

// ===== hw/rtl/floppy_track_format_stream.sv =====
// Top level of the floppy track format stream generator.
// A request word is held in the input register, then its track byte is registered in the result register.
// Throughput: one word per cycle while rsp.ready holds; the position update is one registered pass.
// Reset: arst_n clears position, valid flags and registers (26 sectors, single density).
module floppy_track_format_stream
	import ftf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ftf_req_if.sink     req,
	ftf_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg;

	ftf_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ftf_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
